>>> design/assert_macros.svh
// Concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/fst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

  localparam int MAX_FRAMES_DEF = 256;

  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 1'b1;

  // Command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_LOOP   = 3'd1;
  localparam logic [2:0] CMD_ONCE   = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_REWIND = 3'd4;

  // Play states
  localparam logic [1:0] PS_PAUSED = 2'd0;
  localparam logic [1:0] PS_ONCE   = 2'd1;
  localparam logic [1:0] PS_LOOP   = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] elapsed_ms;
  } fst_in_t;

  typedef struct packed {
    logic [7:0] frame_index;
    logic [1:0] play_state;
  } fst_out_t;

endpackage

`default_nettype wire

>>> design/frame_sequence_timer.sv
`timescale 1ns / 1ps
`default_nettype none

// A command runs ST_RUN (N frame steps), then ST_HOLD, N the frame steps
//   of a playing tick: one per boundary crossed, plus one if it ends mid-frame.
// Throughput: one command at a time; the next is taken the cycle after the
//   result is loaded into the output register.
// Reset (rst_n low, synchronous): paused, frame 0, time left 100 ms,
//   frame_period 100, frame_count 1.
module frame_sequence_timer
  import fst_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fst_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fst_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int FW = $clog2(MAX_FRAMES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          cmd_r;
  logic [15:0]         elapsed_r, elapsed_nxt;
  logic [15:0]         time_left_r, time_left_nxt;
  logic [FW-1:0]       frame_r, frame_nxt;
  logic [1:0]          run_mode_r, run_mode_nxt;
  logic [PERIOD_W-1:0] frame_period_r;
  logic [COUNT_W-1:0]  frame_count_r;
  logic                out_valid_r;
  fst_out_t            out_data_r;

  logic [PERIOD_W-1:0] eff_period;
  logic                playing;
  logic                in_accept;
  logic                out_free;
  logic [15:0]         step_elapsed;
  logic [15:0]         step_time_left;
  logic [FW-1:0]       step_frame;
  logic [1:0]          step_run_mode;

  assign eff_period = (frame_period_r == '0) ? PERIOD_W'(1) : frame_period_r;
  assign playing    = (run_mode_r == PS_ONCE) || (run_mode_r == PS_LOOP);
  assign in_stall   = (state_r != ST_IDLE) || !rst_n;
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = (state_r == ST_IDLE) && rst_n;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  fst_step_unit #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_step (
    .elapsed      (elapsed_r),
    .time_left    (time_left_r),
    .frame        (frame_r),
    .run_mode     (run_mode_r),
    .eff_period   (eff_period),
    .frame_count  (frame_count_r),
    .elapsed_nxt  (step_elapsed),
    .time_left_nxt(step_time_left),
    .frame_nxt    (step_frame),
    .run_mode_nxt (step_run_mode)
  );

  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    time_left_nxt = time_left_r;
    frame_nxt     = frame_r;
    run_mode_nxt  = run_mode_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          elapsed_nxt = in_data.elapsed_ms;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd_r == CMD_TICK && elapsed_r != 16'd0 && playing) begin
          // Consume one frame per cycle
          elapsed_nxt   = step_elapsed;
          time_left_nxt = step_time_left;
          frame_nxt     = step_frame;
          run_mode_nxt  = step_run_mode;
        end else begin
          unique case (cmd_r)
            CMD_LOOP:  run_mode_nxt = PS_LOOP;
            CMD_ONCE:  run_mode_nxt = PS_ONCE;
            CMD_PAUSE: run_mode_nxt = PS_PAUSED;
            CMD_REWIND: begin
              frame_nxt     = '0;
              time_left_nxt = eff_period;
              if (run_mode_r == PS_ONCE) begin
                run_mode_nxt = PS_PAUSED;
              end
            end
            default: ;
          endcase
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      time_left_r    <= PERIOD_RESET;
      frame_r        <= '0;
      run_mode_r     <= PS_PAUSED;
      frame_period_r <= PERIOD_RESET;
      frame_count_r  <= COUNT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_left_r <= time_left_nxt;
      frame_r     <= frame_nxt;
      run_mode_r  <= run_mode_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FRAME_PERIOD: frame_period_r <= cfg_data;
          REG_FRAME_COUNT:  frame_count_r  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    if (in_accept) begin
      cmd_r <= in_data.mode;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_data_r.frame_index <= 8'(frame_r);
      out_data_r.play_state  <= run_mode_r;
    end
  end

  `ASSERT_CLK(a_time_left_nonzero, time_left_r != 16'd0, "time left reached zero")
  `ASSERT_CLK(a_accept_starts_run, in_accept |=> state_r == ST_RUN, "accept did not start run")
  `ASSERT_CLK(a_run_mode_legal, run_mode_r != 2'd3, "illegal run mode")
  `ASSERT_CLK(a_result_leaves_hold, (state_r == ST_HOLD && out_free) |=> out_valid_r,
              "result not loaded")

endmodule

`default_nettype wire

>>> design/fst_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// One frame step: a single subtract of elapsed time against the time left
// in the current frame, then a frame advance with wrap when it runs out.
module fst_step_unit
  import fst_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic [15:0]                   elapsed,
  input  wire logic [15:0]                   time_left,
  input  wire logic [$clog2(MAX_FRAMES)-1:0] frame,
  input  wire logic [1:0]                    run_mode,
  input  wire logic [PERIOD_W-1:0]           eff_period,
  input  wire logic [COUNT_W-1:0]            frame_count,
  output logic      [15:0]                   elapsed_nxt,
  output logic      [15:0]                   time_left_nxt,
  output logic      [$clog2(MAX_FRAMES)-1:0] frame_nxt,
  output logic      [1:0]                    run_mode_nxt
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = (FW + 1 > COUNT_W + 1) ? FW + 1 : COUNT_W + 1;

  logic [16:0]   tl_minus;
  logic          expired;
  logic [CW-1:0] eff_count;
  logic [CW-1:0] frame_inc;

  assign tl_minus = {1'b0, time_left} - {1'b0, elapsed};
  // Borrow or exact zero: the frame runs out on this step
  assign expired  = tl_minus[16] || (tl_minus[15:0] == 16'd0);

  always_comb begin
    eff_count = CW'(frame_count);
    if (frame_count == '0) begin
      eff_count = CW'(1);
    end
    if (eff_count > CW'(MAX_FRAMES)) begin
      eff_count = CW'(MAX_FRAMES);
    end
  end

  assign frame_inc = CW'(frame) + CW'(1);

  always_comb begin
    elapsed_nxt   = '0;
    time_left_nxt = tl_minus[15:0];
    frame_nxt     = frame;
    run_mode_nxt  = run_mode;
    if (expired) begin
      // Remaining time carries into the next frame
      elapsed_nxt   = 16'(~tl_minus[15:0] + 16'd1);
      time_left_nxt = eff_period;
      if (frame_inc >= eff_count) begin
        frame_nxt = '0;
        if (run_mode == PS_ONCE) begin
          run_mode_nxt = PS_PAUSED;
        end
      end else begin
        frame_nxt = FW'(frame_inc);
      end
    end
  end

endmodule

`default_nettype wire
